/* rtl/sss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = 5;
  localparam int unsigned ValW     = 32;

  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_TEST    = 3'd2,
    REQ_POP_MIN = 3'd3,
    REQ_POP_MAX = 3'd4
  } req_code_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_TEST,
    OP_POP_MIN,
    OP_POP_MAX,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    STAT_DONE   = 3'd0,
    STAT_DUP    = 3'd1,
    STAT_ABSENT = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_EMPTY  = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]             req_type;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                   ok;
    logic [2:0]             status;
    logic signed [ValW-1:0] out_value;
    logic [CntW-1:0]        count;
    logic signed [ValW-1:0] min_value;
    logic signed [ValW-1:0] max_value;
    logic                   is_empty;
  } rsp_t;

  typedef struct packed {
    op_e                    op;
    logic signed [ValW-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/sss_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sss_front
  import sss_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_stall_o,
  input  wire req_t req_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  wire logic cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  cmd_t       cmd_in;

  // classify the request
  always_comb begin
    cmd_in.value = req_i.value;
    unique case (req_i.req_type)
      REQ_ADD:     cmd_in.op = OP_ADD;
      REQ_REMOVE:  cmd_in.op = OP_REMOVE;
      REQ_TEST:    cmd_in.op = OP_TEST;
      REQ_POP_MIN: cmd_in.op = OP_POP_MIN;
      REQ_POP_MAX: cmd_in.op = OP_POP_MAX;
      default:     cmd_in.op = OP_NONE;
    endcase
  end

  assign req_stall_o = (fill_q == 2'd2);
  assign push        = req_valid_i && !req_stall_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !cmd_pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/sss_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sss_back
  import sss_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      rsp_valid_o,
  input  wire logic rsp_stall_i,
  output rsp_t      rsp_o
);

  localparam logic StExec   = 1'b0;
  localparam logic StReport = 1'b1;

  logic                   state_q, state_d;
  logic signed [ValW-1:0] ent_q   [Capacity];
  logic signed [ValW-1:0] ent_d   [Capacity];
  logic signed [ValW-1:0] ins_ent [Capacity];
  logic signed [ValW-1:0] del_ent [Capacity];
  logic signed [ValW-1:0] pop_ent [Capacity];
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [Capacity-1:0]    lt, eq, prev_lt;
  logic                   found, full, empty;
  logic [CntW-1:0]        last_cnt;
  logic [IdxW-1:0]        last_idx;
  logic signed [ValW-1:0] tail;
  logic                   ok_q, ok_d;
  status_e                stat_q, stat_d;
  logic signed [ValW-1:0] got_q, got_d;
  logic                   rsp_valid_q;
  rsp_t                   rsp_q;
  logic                   load_rsp;

  assign full     = (cnt_q == CntW'(Capacity));
  assign empty    = (cnt_q == '0);
  assign last_cnt = cnt_q - CntW'(1);
  assign last_idx = last_cnt[IdxW-1:0];
  assign tail     = ent_q[last_idx];
  assign found    = |eq;

  // compare the value against every entry at once
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      lt[i] = (CntW'(i) < cnt_q) && (ent_q[i] < cmd_i.value);
      eq[i] = (CntW'(i) < cnt_q) && (ent_q[i] == cmd_i.value);
    end
    prev_lt = {lt[Capacity-2:0], 1'b1};
  end

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      if (lt[i]) begin
        ins_ent[i] = ent_q[i];
      end else if (prev_lt[i]) begin
        ins_ent[i] = cmd_i.value;
      end else begin
        ins_ent[i] = ent_q[(i > 0) ? i - 1 : 0];
      end
    end
    for (int i = 0; i < Capacity - 1; i++) begin
      del_ent[i] = lt[i] ? ent_q[i] : ent_q[i + 1];
      pop_ent[i] = ent_q[i + 1];
    end
    del_ent[Capacity-1] = ent_q[Capacity-1];
    pop_ent[Capacity-1] = ent_q[Capacity-1];
  end

  assign cmd_pop_o = (state_q == StExec) && cmd_valid_i;
  assign load_rsp  = (state_q == StReport) && (!rsp_valid_q || !rsp_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ent_d   = ent_q;
    ok_d    = ok_q;
    stat_d  = stat_q;
    got_d   = got_q;
    unique case (state_q)
      StExec: begin
        if (cmd_valid_i) begin
          ok_d    = 1'b0;
          stat_d  = STAT_DONE;
          got_d   = '0;
          state_d = StReport;
          case (cmd_i.op)
            OP_ADD: begin
              if (found) begin
                stat_d = STAT_DUP;
              end else if (full) begin
                stat_d = STAT_FULL;
              end else begin
                ent_d = ins_ent;
                cnt_d = cnt_q + CntW'(1);
                ok_d  = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (found) begin
                ent_d = del_ent;
                cnt_d = last_cnt;
                ok_d  = 1'b1;
              end else begin
                stat_d = STAT_ABSENT;
              end
            end
            OP_TEST: begin
              if (found) begin
                ok_d = 1'b1;
              end else begin
                stat_d = STAT_ABSENT;
              end
            end
            OP_POP_MIN: begin
              if (empty) begin
                stat_d = STAT_EMPTY;
              end else begin
                got_d = ent_q[0];
                ent_d = pop_ent;
                cnt_d = last_cnt;
                ok_d  = 1'b1;
              end
            end
            OP_POP_MAX: begin
              if (empty) begin
                stat_d = STAT_EMPTY;
              end else begin
                got_d = tail;
                cnt_d = last_cnt;
                ok_d  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StReport: begin
        if (load_rsp) begin
          state_d = StExec;
        end
      end
      default: begin
        state_d = StExec;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StExec;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    ok_q   <= ok_d;
    stat_q <= stat_d;
    got_q  <= got_d;
    if (load_rsp) begin
      rsp_q.ok        <= ok_q;
      rsp_q.status    <= stat_q;
      rsp_q.out_value <= got_q;
      rsp_q.count     <= cnt_q;
      rsp_q.min_value <= empty ? '0 : ent_q[0];
      rsp_q.max_value <= empty ? '0 : tail;
      rsp_q.is_empty  <= empty;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

/* rtl/sorted_set_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sorted set of up to 16 distinct signed 32-bit values held in ascending order.
// Requests (add, remove, member test, extract minimum, extract maximum) are decoded
// into a two-beat queue; the execution side then handles each request in an execute
// step, in which the value is compared against every stored entry at once and the
// entries shift in place, and a report step, in which the result beat, with the
// count, minimum, maximum and empty flag after the request, is loaded into the
// output register; the report step waits while the output is stalled. A new request
// is taken from the queue only once the result of the last one has been loaded.
module sorted_set_store
  import sss_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_stall_o,
  input  wire req_t req_i,
  output logic      rsp_valid_o,
  input  wire logic rsp_stall_i,
  output rsp_t      rsp_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  sss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
